@@ rtl/core/lht_pkg.sv @@
// Shared types, codes and constants of the linear-hashing key set.
package lht_pkg;

   localparam int ENTRIES_PER_PAGE_DEF = 16;
   localparam int MAX_PAGES_DEF        = 256;
   localparam int MAX_BUCKETS_DEF      = 128;

   localparam int KEY_W    = 32;
   localparam int THR_W    = 7;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int BIDX_W   = 7;
   localparam int REC_W    = 13;
   localparam int LHS_W    = REC_W + 7;

   localparam logic [REC_W-1:0] REC_MAX    = 13'd8191;
   localparam logic [THR_W-1:0] THR_RESET  = 7'd75;
   localparam logic [6:0]       PERCENT    = 7'd100;
   localparam logic [KEY_W-1:0] EMPTY_KEY  = 32'h8000_0000;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic key;
      logic vld;
      logic nxt;
      logic head;
   } wen_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BIDX_W-1:0]   bucket;
      logic                split;
   } result_type;

endpackage

@@ rtl/core/lht_store.sv @@
// Page store: slot keys, per-page valid rows, page links and bucket heads.
module lht_store #(
   parameter  int EPP         = lht_pkg::ENTRIES_PER_PAGE_DEF,
   parameter  int MAX_PAGES   = lht_pkg::MAX_PAGES_DEF,
   parameter  int MAX_BUCKETS = lht_pkg::MAX_BUCKETS_DEF,
   localparam int PW          = $clog2(MAX_PAGES),
   localparam int NPW         = $clog2(MAX_PAGES + 1),
   localparam int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
   localparam int SW          = $clog2(MAX_PAGES * EPP)
) (
   input  logic                      clock,
   input  lht_pkg::wen_type          wen,
   input  logic [SW-1:0]             key_waddr,
   input  logic [lht_pkg::KEY_W-1:0] key_wdata,
   input  logic [SW-1:0]             key_raddr,
   output logic [lht_pkg::KEY_W-1:0] key_rdata,
   input  logic [PW-1:0]             vld_waddr,
   input  logic [EPP-1:0]            vld_wdata,
   input  logic [PW-1:0]             vld_raddr,
   output logic [EPP-1:0]            vld_rdata,
   input  logic [PW-1:0]             nxt_waddr,
   input  logic [NPW-1:0]            nxt_wdata,
   input  logic [PW-1:0]             nxt_raddr,
   output logic [NPW-1:0]            nxt_rdata,
   input  logic [BW-1:0]             head_waddr,
   input  logic [PW-1:0]             head_wdata,
   input  logic [BW-1:0]             head_raddr,
   output logic [PW-1:0]             head_rdata
);
   import lht_pkg::*;

   logic [KEY_W-1:0] key_mem  [MAX_PAGES*EPP];
   logic [EPP-1:0]   vld_mem  [MAX_PAGES];
   logic [NPW-1:0]   nxt_mem  [MAX_PAGES];
   logic [PW-1:0]    head_mem [MAX_BUCKETS];

   always_ff @(posedge clock) begin
      if (wen.key) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rdata <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (wen.vld) begin
         vld_mem[vld_waddr] <= vld_wdata;
      end
      vld_rdata <= vld_mem[vld_raddr];
   end

   always_ff @(posedge clock) begin
      if (wen.nxt) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      nxt_rdata <= nxt_mem[nxt_raddr];
   end

   always_ff @(posedge clock) begin
      if (wen.head) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rdata <= head_mem[head_raddr];
   end

endmodule

@@ rtl/core/lht_seq.sv @@
// Sequencer: chain walker with one slot compare per step, insert, delete and split.
module lht_seq #(
   parameter  int EPP         = lht_pkg::ENTRIES_PER_PAGE_DEF,
   parameter  int MAX_PAGES   = lht_pkg::MAX_PAGES_DEF,
   parameter  int MAX_BUCKETS = lht_pkg::MAX_BUCKETS_DEF,
   localparam int PW          = $clog2(MAX_PAGES),
   localparam int NPW         = $clog2(MAX_PAGES + 1),
   localparam int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
   localparam int SW          = $clog2(MAX_PAGES * EPP)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lht_pkg::REQ_W-1:0] req_type,
   input  logic [lht_pkg::KEY_W-1:0] req_key,
   input  logic [lht_pkg::THR_W-1:0] thr,
   output logic                      res_valid,
   input  logic                      res_take,
   output lht_pkg::result_type       res,
   output lht_pkg::wen_type          wen,
   output logic [SW-1:0]             key_waddr,
   output logic [lht_pkg::KEY_W-1:0] key_wdata,
   output logic [SW-1:0]             key_raddr,
   input  logic [lht_pkg::KEY_W-1:0] key_rdata,
   output logic [PW-1:0]             vld_waddr,
   output logic [EPP-1:0]            vld_wdata,
   output logic [PW-1:0]             vld_raddr,
   input  logic [EPP-1:0]            vld_rdata,
   output logic [PW-1:0]             nxt_waddr,
   output logic [NPW-1:0]            nxt_wdata,
   output logic [PW-1:0]             nxt_raddr,
   input  logic [NPW-1:0]            nxt_rdata,
   output logic [BW-1:0]             head_waddr,
   output logic [PW-1:0]             head_wdata,
   output logic [BW-1:0]             head_raddr,
   input  logic [PW-1:0]             head_rdata
);
   import lht_pkg::*;

   localparam int MW    = BW + 1;
   localparam int EW    = (EPP > 1) ? $clog2(EPP) : 1;
   localparam int DW    = $clog2(EPP + 1);
   localparam int CLR_N = (MAX_PAGES > MAX_BUCKETS) ? MAX_PAGES : MAX_BUCKETS;
   localparam int CLW   = $clog2(CLR_N);
   localparam int MULW  = THR_W + NPW;
   localparam int RHS_W = MULW + 9;
   localparam int CW    = (RHS_W > LHS_W) ? RHS_W : LHS_W;
   localparam logic [NPW-1:0] NULL_PG = NPW'(MAX_PAGES);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_HEAD0, S_HEAD1, S_PG, S_PG_LD, S_SL_RD, S_SL_CK,
      S_END, S_CNT, S_LOAD, S_SPLIT0, S_NEED, S_MV_ALLOC, S_MV_END, S_DONE
   } state_type;

   typedef enum logic [1:0] {M_FIND, M_COUNT, M_MOVE} mode_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [CLW-1:0]     clr_ff, clr_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [MW-1:0]      bkt_ff, bkt_in;
   logic [PW-1:0]      cur_page_ff, cur_page_in;
   logic [EW-1:0]      idx_ff, idx_in;
   logic [EPP-1:0]     row_ff, row_in;
   logic [NPW-1:0]     next_ff, next_in;
   logic               free_found_ff, free_found_in;
   logic [PW-1:0]      free_page_ff, free_page_in;
   logic [EW-1:0]      free_idx_ff, free_idx_in;
   logic [EPP-1:0]     free_row_ff, free_row_in;
   logic [NPW-1:0]     pages_ff, pages_in;
   logic [MW-1:0]      bcount_ff, bcount_in;
   logic [MW-1:0]      mod_ff, mod_in;
   logic [REC_W-1:0]   rc_ff, rc_in;
   logic [MULW-1:0]    mul_ff, mul_in;
   logic [PW-1:0]      src_head_ff, src_head_in;
   logic [MW-1:0]      src_ff, src_in;
   logic [MW-1:0]      ins_ff, ins_in;
   logic [MW-1:0]      nmod_ff, nmod_in;
   logic [NPW-1:0]     need_ff, need_in;
   logic [EW-1:0]      fill_ff, fill_in;
   logic [PW-1:0]      dest_page_ff, dest_page_in;
   logic [DW-1:0]      dest_idx_ff, dest_idx_in;
   logic [EPP-1:0]     dest_row_ff, dest_row_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               split_ff, split_in;

   logic [MW-1:0]      hash_b;
   logic [MW-1:0]      pow_p;
   logic [MW-1:0]      nmask;
   logic [EPP-1:0]     slot_bit;
   logic               slot_live;
   logic               moves;
   logic               last_slot;
   logic [CW-1:0]      lhs;
   logic [CW-1:0]      rhs;
   logic [NPW-1:0]     need_eff;
   logic [BW+BIDX_W:0] bkt_wide;

   // Bucket address: modulus is always a power of two, so the non-negative
   // remainder is the low bits of the two's complement key.
   always_comb begin
      hash_b = key_ff[MW-1:0] & (mod_ff - MW'(1));
      if (hash_b >= bcount_ff) begin
         hash_b = hash_b - (mod_ff >> 1);
      end
      if (hash_b >= MW'(MAX_BUCKETS)) begin
         hash_b = '0;
      end
   end

   always_comb begin
      pow_p = '0;
      for (int i = 0; i < MW; i++) begin
         if (bcount_ff[i]) begin
            pow_p = MW'(1) << i;
         end
      end
   end

   assign nmask     = nmod_ff - MW'(1);
   assign slot_bit  = EPP'(1) << idx_ff;
   assign slot_live = row_ff[idx_ff];
   assign moves     = slot_live && ((key_rdata[MW-1:0] & nmask) == ins_ff);
   assign last_slot = (idx_ff == EW'(EPP - 1));
   assign lhs       = CW'(rc_ff) * CW'(PERCENT);
   assign rhs       = CW'(mul_ff) * CW'(EPP);
   assign need_eff  = (need_ff == '0) ? NPW'(1) : need_ff;
   assign bkt_wide  = (BW + BIDX_W + 1)'(bkt_ff);

   assign key_raddr  = SW'(cur_page_ff) * SW'(EPP) + SW'(idx_ff);
   assign vld_raddr  = cur_page_ff;
   assign nxt_raddr  = cur_page_ff;
   assign head_raddr = (mode_ff == M_FIND) ? bkt_ff[BW-1:0] : src_ff[BW-1:0];

   assign req_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);
   assign res.status = status_ff;
   assign res.bucket = bkt_wide[BIDX_W-1:0];
   assign res.split  = split_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      key_in        = key_ff;
      bkt_in        = bkt_ff;
      cur_page_in   = cur_page_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      next_in       = next_ff;
      free_found_in = free_found_ff;
      free_page_in  = free_page_ff;
      free_idx_in   = free_idx_ff;
      free_row_in   = free_row_ff;
      pages_in      = pages_ff;
      bcount_in     = bcount_ff;
      mod_in        = mod_ff;
      rc_in         = rc_ff;
      mul_in        = mul_ff;
      src_head_in   = src_head_ff;
      src_in        = src_ff;
      ins_in        = ins_ff;
      nmod_in       = nmod_ff;
      need_in       = need_ff;
      fill_in       = fill_ff;
      dest_page_in  = dest_page_ff;
      dest_idx_in   = dest_idx_ff;
      dest_row_in   = dest_row_ff;
      status_in     = status_ff;
      split_in      = split_ff;

      wen        = '0;
      key_waddr  = SW'(dest_page_ff) * SW'(EPP) + SW'(dest_idx_ff);
      key_wdata  = key_rdata;
      vld_waddr  = cur_page_ff;
      vld_wdata  = row_ff;
      nxt_waddr  = cur_page_ff;
      nxt_wdata  = pages_ff;
      head_waddr = ins_ff[BW-1:0];
      head_wdata = pages_ff[PW-1:0];

      case (state_ff)
         S_CLEAR: begin
            wen.vld    = ({1'b0, clr_ff} < (CLW + 1)'(MAX_PAGES));
            wen.nxt    = wen.vld;
            wen.head   = ({1'b0, clr_ff} < (CLW + 1)'(MAX_BUCKETS));
            vld_waddr  = clr_ff[PW-1:0];
            vld_wdata  = '0;
            nxt_waddr  = clr_ff[PW-1:0];
            nxt_wdata  = NULL_PG;
            head_waddr = clr_ff[BW-1:0];
            head_wdata = clr_ff[PW-1:0];
            clr_in     = clr_ff + CLW'(1);
            if (clr_ff == CLW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_type;
               key_in    = req_key;
               mode_in   = M_FIND;
               status_in = STATUS_MISS;
               split_in  = 1'b0;
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            bkt_in = hash_b;
            if (key_ff == EMPTY_KEY || req_ff == REQ_UNUSED) begin
               state_in = S_DONE;
            end else begin
               state_in = S_HEAD0;
            end
         end
         S_HEAD0: begin
            state_in = S_HEAD1;
         end
         S_HEAD1: begin
            cur_page_in   = head_rdata;
            src_head_in   = head_rdata;
            free_found_in = 1'b0;
            state_in      = S_PG;
         end
         S_PG: begin
            state_in = S_PG_LD;
         end
         S_PG_LD: begin
            row_in   = vld_rdata;
            next_in  = nxt_rdata;
            idx_in   = '0;
            state_in = S_SL_RD;
         end
         S_SL_RD: begin
            state_in = S_SL_CK;
         end
         S_SL_CK: begin
            if (mode_ff == M_FIND && slot_live && key_rdata == key_ff) begin
               // hit: answer and stop walking
               status_in = (req_ff == REQ_INSERT) ? STATUS_MISS : STATUS_OK;
               if (req_ff == REQ_DELETE) begin
                  wen.vld   = 1'b1;
                  vld_wdata = row_ff & ~slot_bit;
               end
               state_in = S_DONE;
            end else if (mode_ff == M_MOVE && moves && dest_idx_ff == DW'(EPP)) begin
               state_in = S_MV_ALLOC;
            end else begin
               if (mode_ff == M_FIND && !slot_live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_page_in  = cur_page_ff;
                  free_idx_in   = idx_ff;
                  free_row_in   = row_ff | slot_bit;
               end
               if (mode_ff == M_COUNT && moves) begin
                  if (fill_ff == '0) begin
                     need_in = need_ff + NPW'(1);
                  end
                  fill_in = (fill_ff == EW'(EPP - 1)) ? '0 : fill_ff + EW'(1);
               end
               if (mode_ff == M_MOVE && moves) begin
                  wen.key     = 1'b1;
                  dest_row_in = dest_row_ff | (EPP'(1) << dest_idx_ff);
                  dest_idx_in = dest_idx_ff + DW'(1);
                  row_in      = row_ff & ~slot_bit;
               end
               if (last_slot) begin
                  if (mode_ff == M_MOVE) begin
                     wen.vld   = 1'b1;
                     vld_wdata = row_in;
                  end
                  if (next_ff == NULL_PG) begin
                     case (mode_ff)
                        M_FIND:  state_in = S_END;
                        M_COUNT: state_in = S_NEED;
                        default: state_in = S_MV_END;
                     endcase
                  end else begin
                     cur_page_in = next_ff[PW-1:0];
                     state_in    = S_PG;
                  end
               end else begin
                  idx_in   = idx_ff + EW'(1);
                  state_in = S_SL_RD;
               end
            end
         end
         S_END: begin
            if (req_ff != REQ_INSERT) begin
               state_in = S_DONE;
            end else if (free_found_ff) begin
               wen.key   = 1'b1;
               key_waddr = SW'(free_page_ff) * SW'(EPP) + SW'(free_idx_ff);
               key_wdata = key_ff;
               wen.vld   = 1'b1;
               vld_waddr = free_page_ff;
               vld_wdata = free_row_ff;
               state_in  = S_CNT;
            end else if (pages_ff >= NULL_PG) begin
               status_in = STATUS_FULL;
               state_in  = S_DONE;
            end else begin
               // chain full: link a fresh page behind the last one
               wen.nxt   = 1'b1;
               wen.vld   = 1'b1;
               vld_waddr = pages_ff[PW-1:0];
               vld_wdata = EPP'(1);
               wen.key   = 1'b1;
               key_waddr = SW'(pages_ff[PW-1:0]) * SW'(EPP);
               key_wdata = key_ff;
               pages_in  = pages_ff + NPW'(1);
               state_in  = S_CNT;
            end
         end
         S_CNT: begin
            status_in = STATUS_OK;
            if (rc_ff != REC_MAX) begin
               rc_in = rc_ff + REC_W'(1);
            end
            mul_in   = MULW'(thr) * MULW'(pages_ff);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = (lhs >= rhs) ? S_SPLIT0 : S_DONE;
         end
         S_SPLIT0: begin
            if (bcount_ff >= MW'(MAX_BUCKETS)) begin
               state_in = S_DONE;
            end else begin
               ins_in  = bcount_ff;
               src_in  = bcount_ff - pow_p;
               nmod_in = ({1'b0, bcount_ff} + (MW + 1)'(1) > {1'b0, mod_ff}) ?
                         (mod_ff << 1) : mod_ff;
               mode_in  = M_COUNT;
               need_in  = '0;
               fill_in  = '0;
               state_in = S_HEAD0;
            end
         end
         S_NEED: begin
            if ({1'b0, pages_ff} + {1'b0, need_eff} > (NPW + 1)'(MAX_PAGES)) begin
               state_in = S_DONE;
            end else begin
               wen.head     = 1'b1;
               dest_page_in = pages_ff[PW-1:0];
               dest_idx_in  = '0;
               dest_row_in  = '0;
               pages_in     = pages_ff + NPW'(1);
               bcount_in    = ins_ff + MW'(1);
               mod_in       = nmod_ff;
               mode_in      = M_MOVE;
               cur_page_in  = src_head_ff;
               state_in     = S_PG;
            end
         end
         S_MV_ALLOC: begin
            wen.nxt      = 1'b1;
            nxt_waddr    = dest_page_ff;
            wen.vld      = 1'b1;
            vld_waddr    = dest_page_ff;
            vld_wdata    = dest_row_ff;
            dest_page_in = pages_ff[PW-1:0];
            dest_idx_in  = '0;
            dest_row_in  = '0;
            pages_in     = pages_ff + NPW'(1);
            state_in     = S_SL_CK;
         end
         S_MV_END: begin
            wen.vld   = 1'b1;
            vld_waddr = dest_page_ff;
            vld_wdata = dest_row_ff;
            split_in  = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         mode_ff   <= M_FIND;
         clr_ff    <= '0;
         pages_ff  <= NPW'(2);
         bcount_ff <= MW'(2);
         mod_ff    <= MW'(2);
         rc_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         clr_ff    <= clr_in;
         pages_ff  <= pages_in;
         bcount_ff <= bcount_in;
         mod_ff    <= mod_in;
         rc_ff     <= rc_in;
      end
      req_ff        <= req_in;
      key_ff        <= key_in;
      bkt_ff        <= bkt_in;
      cur_page_ff   <= cur_page_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      next_ff       <= next_in;
      free_found_ff <= free_found_in;
      free_page_ff  <= free_page_in;
      free_idx_ff   <= free_idx_in;
      free_row_ff   <= free_row_in;
      mul_ff        <= mul_in;
      src_head_ff   <= src_head_in;
      src_ff        <= src_in;
      ins_ff        <= ins_in;
      nmod_ff       <= nmod_in;
      need_ff       <= need_in;
      fill_ff       <= fill_in;
      dest_page_ff  <= dest_page_in;
      dest_idx_ff   <= dest_idx_in;
      dest_row_ff   <= dest_row_in;
      status_ff     <= status_in;
      split_ff      <= split_in;
   end

endmodule

@@ rtl/core/linear_hash_table.sv @@
// Top level of the linear-hashing key set: threshold register, result register, core.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   request  | req_valid/req_ready  | req_type, req_key
//   response | rsp_valid/rsp_ready  | rsp_status, rsp_bucket_index, rsp_split_done
//   csr      | csr_we               | csr_wdata (split threshold, percent)
//
// One beat at a time. A request walks the chain of its bucket page by page,
// reading each page's valid row and link, then compares one slot at a time
// through the registered key memory. A hit stops the walk early; a stored insert
// then runs the load test, and one that splits adds two walks of the source chain.
// After reset the store clears every page and bucket entry with req_ready low;
// csr writes are taken throughout. A stalled response holds in the result
// register while the next request is already worked on.
module linear_hash_table #(
   parameter int ENTRIES_PER_PAGE = lht_pkg::ENTRIES_PER_PAGE_DEF,
   parameter int MAX_PAGES        = lht_pkg::MAX_PAGES_DEF,
   parameter int MAX_BUCKETS      = lht_pkg::MAX_BUCKETS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lht_pkg::REQ_W-1:0]    req_type,
   input  logic signed [lht_pkg::KEY_W-1:0] req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lht_pkg::BIDX_W-1:0]   rsp_bucket_index,
   output logic                         rsp_split_done,
   input  logic                         csr_we,
   input  logic [lht_pkg::THR_W-1:0]    csr_wdata
);
   import lht_pkg::*;

   localparam int PW  = $clog2(MAX_PAGES);
   localparam int NPW = $clog2(MAX_PAGES + 1);
   localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW  = $clog2(MAX_PAGES * ENTRIES_PER_PAGE);

   logic [THR_W-1:0]    thr_ff, thr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic                res_valid;
   logic                res_take;
   result_type          res;

   wen_type             wen;
   logic [SW-1:0]       key_waddr;
   logic [KEY_W-1:0]    key_wdata;
   logic [SW-1:0]       key_raddr;
   logic [KEY_W-1:0]    key_rdata;
   logic [PW-1:0]       vld_waddr;
   logic [ENTRIES_PER_PAGE-1:0] vld_wdata;
   logic [PW-1:0]       vld_raddr;
   logic [ENTRIES_PER_PAGE-1:0] vld_rdata;
   logic [PW-1:0]       nxt_waddr;
   logic [NPW-1:0]      nxt_wdata;
   logic [PW-1:0]       nxt_raddr;
   logic [NPW-1:0]      nxt_rdata;
   logic [BW-1:0]       head_waddr;
   logic [PW-1:0]       head_wdata;
   logic [BW-1:0]       head_raddr;
   logic [PW-1:0]       head_rdata;

   // The result register is free when empty or being drained this cycle.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      thr_in       = csr_we ? csr_wdata : thr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (res_valid && res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_bucket_index = rsp_ff.bucket;
   assign rsp_split_done   = rsp_ff.split;

   lht_seq #(
      .EPP         (ENTRIES_PER_PAGE),
      .MAX_PAGES   (MAX_PAGES),
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_key    (KEY_W'(req_key)),
      .thr        (thr_ff),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .wen        (wen),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata),
      .vld_waddr  (vld_waddr),
      .vld_wdata  (vld_wdata),
      .vld_raddr  (vld_raddr),
      .vld_rdata  (vld_rdata),
      .nxt_waddr  (nxt_waddr),
      .nxt_wdata  (nxt_wdata),
      .nxt_raddr  (nxt_raddr),
      .nxt_rdata  (nxt_rdata),
      .head_waddr (head_waddr),
      .head_wdata (head_wdata),
      .head_raddr (head_raddr),
      .head_rdata (head_rdata)
   );

   lht_store #(
      .EPP         (ENTRIES_PER_PAGE),
      .MAX_PAGES   (MAX_PAGES),
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_store (
      .clock      (clock),
      .wen        (wen),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata),
      .vld_waddr  (vld_waddr),
      .vld_wdata  (vld_wdata),
      .vld_raddr  (vld_raddr),
      .vld_rdata  (vld_rdata),
      .nxt_waddr  (nxt_waddr),
      .nxt_wdata  (nxt_wdata),
      .nxt_raddr  (nxt_raddr),
      .nxt_rdata  (nxt_rdata),
      .head_waddr (head_waddr),
      .head_wdata (head_wdata),
      .head_raddr (head_raddr),
      .head_rdata (head_rdata)
   );

endmodule

@@ sim/linear_hash_table_tb.sv @@
// Self-checking testbench for the linear-hashing key set: random handshakes, scoreboard.
module linear_hash_table_tb;
   import lht_pkg::*;

   localparam int EPP        = ENTRIES_PER_PAGE_DEF;
   localparam int NPAGES     = MAX_PAGES_DEF;
   localparam int NBUCKETS   = MAX_BUCKETS_DEF;
   localparam int NSLOTS     = NPAGES * EPP;
   localparam int NO_PAGE    = NPAGES;
   localparam int STALL_MAX  = 60000;   // cycles without any beat before giving up
   localparam int TAIL_WAIT  = 300;
   localparam int MAX_REPORT = 10;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [REQ_W-1:0]           req_type = REQ_LOOKUP;
   logic signed [KEY_W-1:0]    req_key = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [BIDX_W-1:0]          rsp_bucket_index;
   logic                       rsp_split_done;
   logic                       csr_we = 1'b0;
   logic [THR_W-1:0]           csr_wdata = '0;

   typedef logic [REQ_W-1:0] op_type;

   typedef struct {
      logic [REQ_W-1:0]        op;
      logic signed [KEY_W-1:0] key;
   } request_type;

   request_type pending_reqs[$];
   result_type  expected_rsps[$];
   logic signed [KEY_W-1:0] stored_keys[$];   // recent inserts, reused for hits

   // Shadow copy of the key store
   logic [KEY_W-1:0] shadow_key[NSLOTS];
   bit               shadow_vld[NSLOTS];
   int               shadow_next[NPAGES];
   int               shadow_head[NBUCKETS];
   int               n_buckets, cur_mod, pages_taken, rec_count, split_pct;

   int  errors, req_beats, rsp_beats, idle_cycles;
   int  n_inserted, n_splits, n_full, n_phase;
   int  req_gap, rsp_hold, req_draws, rsp_draws;
   bit  pool_exhausted;

   linear_hash_table i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_split_done   (rsp_split_done),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow store: bucket addressing, chain walks and bucket splits
   // ---------------------------------------------------------------------
   function automatic int mod_pos(longint k, int m);
      longint r;
      if (m == 0) return 0;
      r = k % longint'(m);
      if (r < 0) r += m;
      return int'(r);
   endfunction

   function automatic int home_bucket(logic signed [KEY_W-1:0] k);
      int b;
      b = mod_pos(longint'(k), cur_mod);
      if (b >= n_buckets) b -= cur_mod / 2;
      if (b >= NBUCKETS) b = 0;
      return b;
   endfunction

   // Slot holding k, or NSLOTS when absent
   function automatic int find_slot(int b, logic [KEY_W-1:0] k);
      int pg, s;
      pg = shadow_head[b % NBUCKETS];
      for (int hop = 0; hop < NPAGES && pg < NO_PAGE; hop++) begin
         for (int i = 0; i < EPP; i++) begin
            s = pg * EPP + i;
            if (shadow_vld[s] && shadow_key[s] == k) return s;
         end
         pg = shadow_next[pg];
      end
      return NSLOTS;
   endfunction

   // Store k in the first free slot of the chain, linking a fresh page if needed
   function automatic bit place_key(int b, logic [KEY_W-1:0] k);
      int pg, s;
      pg = shadow_head[b % NBUCKETS];
      for (int hop = 0; hop < NPAGES && pg < NO_PAGE; hop++) begin
         for (int i = 0; i < EPP; i++) begin
            s = pg * EPP + i;
            if (!shadow_vld[s]) begin
               shadow_key[s] = k;
               shadow_vld[s] = 1'b1;
               return 1'b1;
            end
         end
         if (shadow_next[pg] >= NO_PAGE) begin
            if (pages_taken >= NPAGES) return 1'b0;
            shadow_next[pages_taken] = NO_PAGE;
            shadow_next[pg] = pages_taken;
            pages_taken++;
         end
         pg = shadow_next[pg];
      end
      return 1'b0;
   endfunction

   // Append bucket n_buckets and rehash its partner; 0 when refused
   function automatic bit grow_table();
      int ins, p, src, new_mod, moves, need, pg, s;
      ins = n_buckets;
      p = 2;
      moves = 0;
      if (ins >= NBUCKETS) return 1'b0;
      while (p <= ins) p *= 2;
      p /= 2;
      src = ins - p;
      new_mod = (ins + 1 > cur_mod) ? 2 * cur_mod : cur_mod;
      pg = shadow_head[src % NBUCKETS];
      for (int hop = 0; hop < NPAGES && pg < NO_PAGE; hop++) begin
         for (int i = 0; i < EPP; i++) begin
            s = pg * EPP + i;
            if (shadow_vld[s] &&
                mod_pos(longint'($signed(shadow_key[s])), new_mod) == ins) moves++;
         end
         pg = shadow_next[pg];
      end
      need = (moves + EPP - 1) / EPP;
      if (need == 0) need = 1;
      if (pages_taken + need > NPAGES) return 1'b0;
      shadow_head[ins] = pages_taken;
      shadow_next[pages_taken] = NO_PAGE;
      pages_taken++;
      n_buckets = ins + 1;
      cur_mod = new_mod;
      pg = shadow_head[src % NBUCKETS];
      for (int hop = 0; hop < NPAGES && pg < NO_PAGE; hop++) begin
         for (int i = 0; i < EPP; i++) begin
            s = pg * EPP + i;
            if (shadow_vld[s] &&
                mod_pos(longint'($signed(shadow_key[s])), new_mod) == ins) begin
               if (place_key(ins, shadow_key[s])) shadow_vld[s] = 1'b0;
            end
         end
         pg = shadow_next[pg];
      end
      return 1'b1;
   endfunction

   // Apply one request to the shadow store and return the response it must give
   function automatic result_type apply_request(logic [REQ_W-1:0] op,
                                                logic signed [KEY_W-1:0] k);
      result_type r;
      int b, s;
      bit marker;
      longint lhs, rhs;
      b = home_bucket(k);
      marker = (k == EMPTY_KEY);
      r.status = STATUS_MISS;
      r.bucket = b[BIDX_W-1:0];
      r.split  = 1'b0;
      case (op)
         REQ_INSERT: begin
            if (!marker && find_slot(b, k) == NSLOTS) begin
               if (!place_key(b, k)) begin
                  r.status = STATUS_FULL;
                  n_full++;
                  pool_exhausted = 1'b1;
               end else begin
                  r.status = STATUS_OK;
                  n_inserted++;
                  stored_keys.insert(stored_keys.size(), k);
                  if (stored_keys.size() > 512) void'(stored_keys.pop_front());
                  if (rec_count < int'(REC_MAX)) rec_count++;
                  lhs = longint'(rec_count) * 100;
                  rhs = longint'(split_pct) * pages_taken * EPP;
                  if (lhs >= rhs && grow_table()) begin
                     r.split = 1'b1;
                     n_splits++;
                  end
               end
            end
         end
         REQ_LOOKUP: begin
            if (!marker && find_slot(b, k) != NSLOTS) r.status = STATUS_OK;
         end
         REQ_DELETE: begin
            if (!marker) begin
               s = find_slot(b, k);
               if (s < NSLOTS) begin
                  shadow_vld[s] = 1'b0;
                  r.status = STATUS_OK;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Idle draw with a quiet stretch every third block of forty draws
   function automatic int draw_idle(ref int count);
      count++;
      if ((count / 40) % 3 == 2) return 0;
      return $urandom_range(0, 17);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: predict on every accepted beat, then load the next one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.insert(expected_rsps.size(), apply_request(req_type, req_key));
            req_beats++;
         end
         // Only touch the payload when the current beat is gone or none is held
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_type  <= nxt.op;
               req_key   <= nxt.key;
               req_gap = draw_idle(req_draws);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORT)
                  $display("ERROR: unexpected response beat status=%0d bucket=%0d split=%0b",
                           rsp_status, rsp_bucket_index, rsp_split_done);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status || rsp_bucket_index !== want.bucket ||
                   rsp_split_done !== want.split) begin
                  errors++;
                  if (errors <= MAX_REPORT) begin
                     $display("ERROR: response %0d expected status=%0d bucket=%0d split=%0b",
                              rsp_beats, want.status, want.bucket, want.split);
                     $display("       got status=%0d bucket=%0d split=%0b",
                              rsp_status, rsp_bucket_index, rsp_split_done);
                  end
               end
            end
            rsp_hold = draw_idle(rsp_draws);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // Watchdog: any beat on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("ERROR: no beat for %0d cycles", STALL_MAX);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_req(logic [REQ_W-1:0] op, logic signed [KEY_W-1:0] k);
      request_type it;
      it.op  = op;
      it.key = k;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key(bit from_store);
      if (from_store && stored_keys.size() > 0)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      return $signed($urandom);
   endfunction

   task automatic push_random(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 55)      push_req(REQ_INSERT, pick_key(r < 8));
         else if (r < 75) push_req(REQ_LOOKUP, pick_key(r < 68));
         else if (r < 95) push_req(REQ_DELETE, pick_key(r < 90));
         else if (r < 97) push_req(REQ_UNUSED, pick_key(1'b0));
         else             push_req(op_type'($urandom_range(0, 2)), EMPTY_KEY);
      end
   endtask

   // Hold until every request is sent and every response is back
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] pct);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= pct;
      split_pct = pct;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic signed [KEY_W-1:0] k;
      for (int i = 0; i < NPAGES; i++) shadow_next[i] = NO_PAGE;
      for (int i = 0; i < NBUCKETS; i++) shadow_head[i] = i % NPAGES;
      n_buckets = 2;
      cur_mod = 2;
      pages_taken = 2;
      rec_count = 0;
      split_pct = THR_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, marker key, unused code
      push_req(REQ_INSERT, 32'sd0);
      push_req(REQ_INSERT, 32'sd1);
      push_req(REQ_INSERT, -32'sd1);
      push_req(REQ_INSERT, 32'sh7FFF_FFFF);
      push_req(REQ_INSERT, 32'sh8000_0001);
      push_req(REQ_INSERT, 32'sh8000_0001);   // duplicate
      push_req(REQ_INSERT, EMPTY_KEY);
      push_req(REQ_LOOKUP, EMPTY_KEY);
      push_req(REQ_DELETE, EMPTY_KEY);
      push_req(REQ_LOOKUP, 32'sh7FFF_FFFF);
      push_req(REQ_LOOKUP, 32'sh5555_5555);   // absent
      push_req(REQ_DELETE, -32'sd1);
      push_req(REQ_DELETE, -32'sd1);          // now absent
      push_req(REQ_LOOKUP, -32'sd1);
      push_req(REQ_UNUSED, 32'sd1);
      push_req(REQ_UNUSED, 32'shFFFF_FFFF);
      push_req(REQ_INSERT, 32'shAAAA_AAAA);
      push_req(REQ_INSERT, 32'sh5555_5555);
      push_req(REQ_INSERT, -32'sd2);
      push_req(REQ_LOOKUP, 32'sd0);
      drain();
      n_phase++;

      // Random phases under a spread of thresholds, extremes included
      for (int i = 0; i < 6; i++) begin
         case (i)
            0: write_threshold(7'd100);
            1: write_threshold(7'd127);
            2: write_threshold(7'd1);
            3: write_threshold(THR_W'($urandom_range(1, 100)));
            4: write_threshold(7'd60);
            default: write_threshold(THR_RESET);
         endcase
         push_random(130);
         drain();
         n_phase++;
      end

      // Fill phase: split every insert up to the bucket limit, then crowd
      // sixteen buckets with overflow pages
      write_threshold(7'd0);
      for (int blk = 0; blk < 14 && !pool_exhausted; blk++) begin
         for (int n = 0; n < 64; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               push_req(REQ_LOOKUP, pick_key(1'b1));
            end else begin
               k = $signed($urandom);
               k[6:4] = 3'b000;
               push_req(REQ_INSERT, k);
            end
         end
         drain();
      end
      push_random(40);
      drain();
      n_phase++;

      repeat (TAIL_WAIT) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         errors++;
         $display("ERROR: %0d responses never arrived", expected_rsps.size());
      end

      $display("Run: %0d requests, %0d responses over %0d phases; %0d keys stored, %0d splits,",
               req_beats, rsp_beats, n_phase, n_inserted, n_splits);
      $display("     %0d buckets and %0d pages in use, %0d inserts refused on a full pool",
               n_buckets, pages_taken, n_full);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
